[rtl/core/ssf_pkg.sv]
// Shared types and constants of the seek steering force core.
package ssf_pkg;

	localparam int SPEED_W = 23;
	localparam int GAIN_W  = 16;
	localparam int FORCE_W = 32;
	localparam int QUO_W   = 25;

	localparam int BRAKE_SHIFT = 9;
	localparam int SEEK_SHIFT  = 8;

	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t REG_TARGET_X   = 3'd0;
	localparam cfg_idx_t REG_TARGET_Y   = 3'd1;
	localparam cfg_idx_t REG_TARGET_Z   = 3'd2;
	localparam cfg_idx_t REG_MAX_SPEED  = 3'd3;
	localparam cfg_idx_t REG_ACCEL_GAIN = 3'd4;
	localparam cfg_idx_t REG_STOP_DIST  = 3'd5;

	localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 23'd153600;
	localparam logic [GAIN_W-1:0]  ACCEL_GAIN_RST = 16'd256;
	localparam logic [SPEED_W-1:0] STOP_DIST_RST  = 23'd25600;

	typedef struct packed {
		logic       brake;
		logic       sh;
		logic [2:0] neg;
	} ssf_flags_t;

endpackage

[rtl/core/ssf_front.sv]
// Offset, squared distance, braking test and speed numerators in three stages.
module ssf_front #(
	parameter int COORD_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic signed [COORD_BITS-1:0]         pos_x,
	input  logic signed [COORD_BITS-1:0]         pos_y,
	input  logic signed [COORD_BITS-1:0]         pos_z,
	input  logic signed [COORD_BITS-1:0]         vel_x,
	input  logic signed [COORD_BITS-1:0]         vel_y,
	input  logic signed [COORD_BITS-1:0]         vel_z,
	input  logic signed [COORD_BITS-1:0]         target_x,
	input  logic signed [COORD_BITS-1:0]         target_y,
	input  logic signed [COORD_BITS-1:0]         target_z,
	input  logic [ssf_pkg::SPEED_W-1:0]          max_speed,
	input  logic [ssf_pkg::SPEED_W-1:0]          stop_distance,
	output logic                                 out_valid,
	output ssf_pkg::ssf_flags_t                  flags,
	output logic [2*COORD_BITS+1:0]              rad,
	output logic signed [COORD_BITS-1:0]         vel [3],
	output logic [COORD_BITS+ssf_pkg::SPEED_W-1:0] num [3]
);

	localparam int CB = COORD_BITS;
	localparam int SW = 2 * CB + 2;
	localparam int AW = CB + ssf_pkg::SPEED_W;
	localparam int QW = 2 * ssf_pkg::SPEED_W;
	localparam int CW = (SW > QW) ? SW : QW;

	logic signed [CB-1:0] pos [3];
	logic signed [CB-1:0] tgt [3];
	logic signed [CB-1:0] vin [3];

	logic                 vld_s1;
	logic signed [CB:0]   d_s1 [3];
	logic signed [CB-1:0] v_s1 [3];

	logic                 vld_s2;
	logic [CB-1:0]        m_s2 [3];
	logic [2*CB-1:0]      sq_s2 [3];
	logic [AW-1:0]        num_s2 [3];
	logic signed [CB-1:0] v_s2 [3];
	logic                 sh_s2;
	logic [2:0]           neg_s2;

	logic                 vld_s3;
	ssf_pkg::ssf_flags_t  flags_s3;
	logic [SW-1:0]        rad_s3;
	logic signed [CB-1:0] v_s3 [3];
	logic [AW-1:0]        num_s3 [3];

	logic [QW-1:0]        stop_sq_q;

	logic [CB:0]          negd [3];
	logic [CB-1:0]        mag [3];
	logic                 big;
	logic [2*CB-1:0]      corr [3];
	logic [2*CB-1:0]      tsq [3];
	logic [SW-1:0]        msum;
	logic [SW-1:0]        tsum;
	ssf_pkg::ssf_flags_t  flags_c;

	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;
	assign tgt[0] = target_x;
	assign tgt[1] = target_y;
	assign tgt[2] = target_z;
	assign vin[0] = vel_x;
	assign vin[1] = vel_y;
	assign vin[2] = vel_z;

	always_ff @(posedge clk) begin
		stop_sq_q <= QW'(stop_distance) * QW'(stop_distance);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= (CB+1)'(tgt[i]) - (CB+1)'(pos[i]);
				v_s1[i] <= vin[i];
			end
		end
	end

	always_comb begin
		big = 1'b0;
		for (int i = 0; i < 3; i++) begin
			negd[i] = -d_s1[i];
			mag[i] = d_s1[i][CB] ? negd[i][CB-1:0] : d_s1[i][CB-1:0];
			if (64'(mag[i]) >= 64'h8000_0000) begin
				big = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_s2[i]   <= mag[i];
				sq_s2[i]  <= (2*CB)'(mag[i]) * (2*CB)'(mag[i]);
				num_s2[i] <= AW'(mag[i]) * AW'(max_speed);
				v_s2[i]   <= v_s1[i];
				neg_s2[i] <= d_s1[i][CB];
			end
			sh_s2 <= big;
		end
	end

	// The halved magnitude squared follows from the full square: (m^2 - (2m-1)) / 4 for odd m.
	always_comb begin
		msum = '0;
		tsum = '0;
		for (int i = 0; i < 3; i++) begin
			corr[i] = m_s2[i][0] ? ((2*CB)'({m_s2[i], 1'b0}) - (2*CB)'(1)) : '0;
			tsq[i]  = (sq_s2[i] - corr[i]) >> 2;
			msum    = msum + SW'(sq_s2[i]);
			tsum    = tsum + SW'(tsq[i]);
		end
		flags_c.brake = (CW'(msum) <= CW'(stop_sq_q));
		flags_c.sh    = sh_s2;
		flags_c.neg   = neg_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s3 <= flags_c;
			rad_s3   <= sh_s2 ? tsum : msum;
			for (int i = 0; i < 3; i++) begin
				v_s3[i]   <= v_s2[i];
				num_s3[i] <= num_s2[i];
			end
		end
	end

	assign out_valid = vld_s3;
	assign flags     = flags_s3;
	assign rad       = rad_s3;
	assign vel       = v_s3;
	assign num       = num_s3;

endmodule

[rtl/core/ssf_sqrt.sv]
// Pipelined integer square root, two result bits per stage.
module ssf_sqrt #(
	parameter int RW = 25,
	parameter int TW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RW-1:0] rad,
	input  logic [TW-1:0]   in_tag,
	output logic            out_valid,
	output logic [RW-1:0]   root,
	output logic [TW-1:0]   out_tag
);

	localparam int NST = (RW + 1) / 2;
	localparam int PW  = 2 * NST;
	localparam int XW  = 2 * PW;

	logic [XW-1:0] x_s    [NST];
	logic [PW+1:0] rem_s  [NST];
	logic [PW-1:0] root_s [NST];
	logic [TW-1:0] tag_s  [NST];
	logic          vld_s  [NST];

	function automatic logic [2*PW+1:0] sq_step(input logic [PW+1:0] rem,
		input logic [PW-1:0] rt, input logic [1:0] pair);
		logic [PW+3:0] acc;
		logic [PW+3:0] trial;
		logic [PW+3:0] diff;
		acc   = {rem, pair};
		trial = {2'b00, rt, 2'b01};
		diff  = acc - trial;
		if (acc >= trial) begin
			return {diff[PW+1:0], rt[PW-2:0], 1'b1};
		end
		return {acc[PW+1:0], rt[PW-2:0], 1'b0};
	endfunction

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic [XW-1:0]     xi;
		logic [PW+1:0]     ri;
		logic [PW-1:0]     qi;
		logic [TW-1:0]     ti;
		logic              vi;
		logic [2*PW+1:0]   st1;
		logic [2*PW+1:0]   st2;

		if (k == 0) begin : g_in
			assign xi = XW'(rad);
			assign ri = '0;
			assign qi = '0;
			assign ti = in_tag;
			assign vi = in_valid;
		end else begin : g_mid
			assign xi = x_s[k-1];
			assign ri = rem_s[k-1];
			assign qi = root_s[k-1];
			assign ti = tag_s[k-1];
			assign vi = vld_s[k-1];
		end

		assign st1 = sq_step(ri, qi, xi[XW-1 -: 2]);
		assign st2 = sq_step(st1[2*PW+1 -: PW+2], st1[PW-1:0], xi[XW-3 -: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]    <= xi << 4;
				rem_s[k]  <= st2[2*PW+1 -: PW+2];
				root_s[k] <= st2[PW-1:0];
				tag_s[k]  <= ti;
			end
		end
	end

	assign out_valid = vld_s[NST-1];
	assign root      = root_s[NST-1][RW-1:0];
	assign out_tag   = tag_s[NST-1];

endmodule

[rtl/core/ssf_div.sv]
// Pipelined rounded division of three numerators by one length, two quotient bits per stage.
module ssf_div #(
	parameter int NW = 48,
	parameter int DW = 25,
	parameter int QW = 25,
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num [3],
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] in_tag,
	output logic          out_valid,
	output logic [QW-1:0] quo [3],
	output logic [TW-1:0] out_tag
);

	localparam int NST = (QW + 1) / 2;
	localparam int PW  = 2 * NST;

	logic          vld_s0;
	logic [NW-1:0] nsum_s0 [3];
	logic [DW-1:0] den_s0;
	logic [TW-1:0] tag_s0;

	logic [DW-1:0] rem_s [NST][3];
	logic [PW-1:0] low_s [NST][3];
	logic [PW-1:0] q_s   [NST][3];
	logic [DW-1:0] den_s [NST];
	logic [TW-1:0] tag_s [NST];
	logic          vld_s [NST];

	function automatic logic [DW+PW-1:0] div_step(input logic [DW-1:0] rem,
		input logic nb, input logic [PW-1:0] q, input logic [DW-1:0] dv);
		logic [DW:0] acc;
		logic [DW:0] diff;
		acc  = {rem, nb};
		diff = acc - {1'b0, dv};
		if (acc >= {1'b0, dv}) begin
			return {diff[DW-1:0], q[PW-2:0], 1'b1};
		end
		return {acc[DW-1:0], q[PW-2:0], 1'b0};
	endfunction

	// Adding half the divisor first makes the floor quotient round to nearest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nsum_s0[i] <= num[i] + NW'(den >> 1);
			end
			den_s0 <= den;
			tag_s0 <= in_tag;
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic [DW-1:0] ri [3];
		logic [PW-1:0] li [3];
		logic [PW-1:0] qi [3];
		logic [DW-1:0] dn;
		logic [TW-1:0] ti;
		logic          vi;

		if (k == 0) begin : g_in
			for (genvar l = 0; l < 3; l++) begin : g_ln
				assign ri[l] = DW'(nsum_s0[l] >> PW);
				assign li[l] = nsum_s0[l][PW-1:0];
				assign qi[l] = '0;
			end
			assign dn = den_s0;
			assign ti = tag_s0;
			assign vi = vld_s0;
		end else begin : g_mid
			for (genvar l = 0; l < 3; l++) begin : g_ln
				assign ri[l] = rem_s[k-1][l];
				assign li[l] = low_s[k-1][l];
				assign qi[l] = q_s[k-1][l];
			end
			assign dn = den_s[k-1];
			assign ti = tag_s[k-1];
			assign vi = vld_s[k-1];
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [DW+PW-1:0] st1;
			logic [DW+PW-1:0] st2;

			assign st1 = div_step(ri[l], li[l][PW-1], qi[l], dn);
			assign st2 = div_step(st1[DW+PW-1 -: DW], li[l][PW-2], st1[PW-1:0], dn);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= st2[DW+PW-1 -: DW];
					low_s[k][l] <= li[l] << 2;
					q_s[k][l]   <= st2[PW-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= dn;
				tag_s[k] <= ti;
			end
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_out
		assign quo[l] = q_s[NST-1][l][QW-1:0];
	end

	assign out_valid = vld_s[NST-1];
	assign out_tag   = tag_s[NST-1];

endmodule

[rtl/core/ssf_out.sv]
// Velocity error, gain multiply, rounding and saturation in three stages.
module ssf_out #(
	parameter int COORD_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  ssf_pkg::ssf_flags_t                 flags,
	input  logic [ssf_pkg::QUO_W-1:0]           quo [3],
	input  logic signed [COORD_BITS-1:0]        vel [3],
	input  logic [ssf_pkg::GAIN_W-1:0]          accel_gain,
	output logic                                out_valid,
	output logic signed [ssf_pkg::FORCE_W-1:0]  frc [3],
	output logic                                braking
);

	localparam int QW = ssf_pkg::QUO_W;
	localparam int FW = ssf_pkg::FORCE_W;
	localparam int OW = ((QW + 1 > COORD_BITS) ? QW + 1 : COORD_BITS) + 1;
	localparam int MW = OW + ssf_pkg::GAIN_W + 1;

	logic                 vld_s1;
	logic                 brake_s1;
	logic signed [OW-1:0] op_s1 [3];

	logic                 vld_s2;
	logic                 brake_s2;
	logic signed [MW-1:0] p_s2 [3];

	logic                 vld_s3;
	logic                 brake_s3;
	logic signed [FW-1:0] frc_s3 [3];

	logic signed [OW-1:0] qe [3];
	logic signed [OW-1:0] ve [3];
	logic signed [OW-1:0] want [3];
	logic signed [OW-1:0] op [3];
	logic signed [ssf_pkg::GAIN_W:0] gain_s;
	logic [MW-1:0]        ab [3];
	logic [MW-1:0]        rnd [3];
	logic [MW-1:0]        half;
	logic signed [FW-1:0] fc [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qe[i]   = signed'(OW'(quo[i]));
			ve[i]   = OW'(vel[i]);
			want[i] = flags.neg[i] ? -qe[i] : qe[i];
			op[i]   = flags.brake ? -ve[i] : (want[i] - ve[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			brake_s1 <= flags.brake;
			op_s1    <= op;
		end
	end

	assign gain_s = signed'({1'b0, accel_gain});

	always_ff @(posedge clk) begin
		if (en) begin
			brake_s2 <= brake_s1;
			for (int i = 0; i < 3; i++) begin
				p_s2[i] <= MW'(op_s1[i]) * MW'(gain_s);
			end
		end
	end

	// Round half away from zero on the magnitude, then clamp to the force range.
	always_comb begin
		half = brake_s2 ? (MW'(1) << (ssf_pkg::BRAKE_SHIFT - 1))
			: (MW'(1) << (ssf_pkg::SEEK_SHIFT - 1));
		for (int i = 0; i < 3; i++) begin
			ab[i]  = p_s2[i][MW-1] ? MW'(-p_s2[i]) : MW'(p_s2[i]);
			rnd[i] = brake_s2 ? ((ab[i] + half) >> ssf_pkg::BRAKE_SHIFT)
				: ((ab[i] + half) >> ssf_pkg::SEEK_SHIFT);
			if (!p_s2[i][MW-1]) begin
				if (rnd[i] > MW'({1'b0, {(FW-1){1'b1}}})) begin
					fc[i] = {1'b0, {(FW-1){1'b1}}};
				end else begin
					fc[i] = rnd[i][FW-1:0];
				end
			end else begin
				if (rnd[i] >= MW'({1'b1, {(FW-1){1'b0}}})) begin
					fc[i] = {1'b1, {(FW-1){1'b0}}};
				end else begin
					fc[i] = -signed'(rnd[i][FW-1:0]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			brake_s3 <= brake_s2;
			frc_s3   <= fc;
		end
	end

	assign out_valid = vld_s3;
	assign frc       = frc_s3;
	assign braking   = brake_s3;

endmodule

[rtl/core/seek_steering_force_core.sv]
// Top level of the seek steering force core: registers, pipeline and output skid stage.
//
//   channel | direction | handshake            | beat
//   in      | input     | in_valid / in_stall   | pos_x..pos_z, vel_x..vel_z
//   out     | output    | out_valid / out_stall | force_x..force_z, braking
//   cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// One beat is taken every cycle while in_stall is low; a result passes through the front,
// square root, divider and output stage chains in that order.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A stalled result moves into a skid register; in_stall is high only while it is full.
module seek_steering_force_core #(
	parameter int COORD_BITS = 24
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_stall,
	input  logic signed [COORD_BITS-1:0]                  pos_x,
	input  logic signed [COORD_BITS-1:0]                  pos_y,
	input  logic signed [COORD_BITS-1:0]                  pos_z,
	input  logic signed [COORD_BITS-1:0]                  vel_x,
	input  logic signed [COORD_BITS-1:0]                  vel_y,
	input  logic signed [COORD_BITS-1:0]                  vel_z,
	output logic                                          out_valid,
	input  logic                                          out_stall,
	output logic signed [ssf_pkg::FORCE_W-1:0]            force_x,
	output logic signed [ssf_pkg::FORCE_W-1:0]            force_y,
	output logic signed [ssf_pkg::FORCE_W-1:0]            force_z,
	output logic                                          braking,
	input  logic                                          cfg_we,
	input  ssf_pkg::cfg_idx_t                             cfg_index,
	input  logic [((COORD_BITS > 23) ? COORD_BITS : 23)-1:0] cfg_data
);

	localparam int CB  = COORD_BITS;
	localparam int RW  = CB + 1;
	localparam int AW  = CB + ssf_pkg::SPEED_W;
	localparam int NW  = AW + 1;
	localparam int FLW = $bits(ssf_pkg::ssf_flags_t);
	localparam int TW1 = FLW + 3 * CB + 3 * AW;
	localparam int TW2 = FLW + 3 * CB;
	localparam int FW  = ssf_pkg::FORCE_W;

	logic signed [CB-1:0]          target_x_q;
	logic signed [CB-1:0]          target_y_q;
	logic signed [CB-1:0]          target_z_q;
	logic [ssf_pkg::SPEED_W-1:0]   max_speed_q;
	logic [ssf_pkg::GAIN_W-1:0]    accel_gain_q;
	logic [ssf_pkg::SPEED_W-1:0]   stop_distance_q;

	logic                          en;

	logic                          fr_valid;
	ssf_pkg::ssf_flags_t           fr_flags;
	logic [2*RW-1:0]               fr_rad;
	logic signed [CB-1:0]          fr_vel [3];
	logic [AW-1:0]                 fr_num [3];

	logic [TW1-1:0]                sq_tag_in;
	logic [TW1-1:0]                sq_tag_out;
	logic                          sq_valid;
	logic [RW-1:0]                 sq_root;
	ssf_pkg::ssf_flags_t           sq_flags;
	logic signed [CB-1:0]          sq_vel [3];
	logic [AW-1:0]                 sq_num [3];
	logic [NW-1:0]                 dv_num [3];
	logic [RW-1:0]                 len_raw;
	logic [RW-1:0]                 len;

	logic [TW2-1:0]                dv_tag_in;
	logic [TW2-1:0]                dv_tag_out;
	logic                          dv_valid;
	logic [ssf_pkg::QUO_W-1:0]     dv_quo [3];
	ssf_pkg::ssf_flags_t           dv_flags;
	logic signed [CB-1:0]          dv_vel [3];

	logic                          op_valid;
	logic signed [FW-1:0]          op_frc [3];
	logic                          op_braking;

	logic                          skid_full_q;
	logic signed [FW-1:0]          skid_frc_q [3];
	logic                          skid_braking_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q      <= '0;
			target_y_q      <= '0;
			target_z_q      <= '0;
			max_speed_q     <= ssf_pkg::MAX_SPEED_RST;
			accel_gain_q    <= ssf_pkg::ACCEL_GAIN_RST;
			stop_distance_q <= ssf_pkg::STOP_DIST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssf_pkg::REG_TARGET_X: begin
					target_x_q <= cfg_data[CB-1:0];
				end
				ssf_pkg::REG_TARGET_Y: begin
					target_y_q <= cfg_data[CB-1:0];
				end
				ssf_pkg::REG_TARGET_Z: begin
					target_z_q <= cfg_data[CB-1:0];
				end
				ssf_pkg::REG_MAX_SPEED: begin
					max_speed_q <= cfg_data[ssf_pkg::SPEED_W-1:0];
				end
				ssf_pkg::REG_ACCEL_GAIN: begin
					accel_gain_q <= cfg_data[ssf_pkg::GAIN_W-1:0];
				end
				ssf_pkg::REG_STOP_DIST: begin
					stop_distance_q <= cfg_data[ssf_pkg::SPEED_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;

	ssf_front #(
		.COORD_BITS(CB)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (in_valid),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.vel_z        (vel_z),
		.target_x     (target_x_q),
		.target_y     (target_y_q),
		.target_z     (target_z_q),
		.max_speed    (max_speed_q),
		.stop_distance(stop_distance_q),
		.out_valid    (fr_valid),
		.flags        (fr_flags),
		.rad          (fr_rad),
		.vel          (fr_vel),
		.num          (fr_num)
	);

	assign sq_tag_in = {fr_flags, fr_vel[0], fr_vel[1], fr_vel[2],
		fr_num[0], fr_num[1], fr_num[2]};

	ssf_sqrt #(
		.RW(RW),
		.TW(TW1)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fr_valid),
		.rad      (fr_rad),
		.in_tag   (sq_tag_in),
		.out_valid(sq_valid),
		.root     (sq_root),
		.out_tag  (sq_tag_out)
	);

	assign {sq_flags, sq_vel[0], sq_vel[1], sq_vel[2],
		sq_num[0], sq_num[1], sq_num[2]} = sq_tag_out;

	assign len_raw = sq_flags.sh ? {sq_root[RW-2:0], 1'b0} : sq_root;
	assign len     = (len_raw == '0) ? RW'(1) : len_raw;

	for (genvar l = 0; l < 3; l++) begin : g_num
		assign dv_num[l] = NW'(sq_num[l]);
	end

	assign dv_tag_in = {sq_flags, sq_vel[0], sq_vel[1], sq_vel[2]};

	ssf_div #(
		.NW(NW),
		.DW(RW),
		.QW(ssf_pkg::QUO_W),
		.TW(TW2)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.num      (dv_num),
		.den      (len),
		.in_tag   (dv_tag_in),
		.out_valid(dv_valid),
		.quo      (dv_quo),
		.out_tag  (dv_tag_out)
	);

	assign {dv_flags, dv_vel[0], dv_vel[1], dv_vel[2]} = dv_tag_out;

	ssf_out #(
		.COORD_BITS(CB)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_valid),
		.flags     (dv_flags),
		.quo       (dv_quo),
		.vel       (dv_vel),
		.accel_gain(accel_gain_q),
		.out_valid (op_valid),
		.frc       (op_frc),
		.braking   (op_braking)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (!skid_full_q) begin
			if (op_valid && out_stall) begin
				skid_full_q <= 1'b1;
			end
		end else if (!out_stall) begin
			skid_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			skid_frc_q     <= op_frc;
			skid_braking_q <= op_braking;
		end
	end

	assign out_valid = skid_full_q | op_valid;
	assign force_x   = skid_full_q ? skid_frc_q[0] : op_frc[0];
	assign force_y   = skid_full_q ? skid_frc_q[1] : op_frc[1];
	assign force_z   = skid_full_q ? skid_frc_q[2] : op_frc[2];
	assign braking   = skid_full_q ? skid_braking_q : op_braking;

endmodule

[rtl/core/ssf_checker.sv]
// Port-level checker for the seek steering force core and its bind.
module ssf_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [ssf_pkg::FORCE_W-1:0] force_x,
	input logic                               braking
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Output beat dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(force_x) && $stable(braking))
		else $error("Output beat changed while stalled.");

	a_stall_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("Input stalled with no result waiting.");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && !in_stall |=> in_stall)
		else $error("Stalled result not parked in the skid register.");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |=> !in_stall)
		else $error("Input stall held after the parked result left.");

endmodule

bind seek_steering_force_core ssf_checker u_ssf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.force_x  (force_x),
	.braking  (braking)
);

[tb/tb_seek_steering_force_core.sv]
// Self-checking testbench of the seek steering force core: directed table, random beats, predictor.
module tb_seek_steering_force_core;

	localparam int CB = 24;
	localparam int CW = 24;
	localparam int LATENCY = 33;
	localparam int WATCHDOG = 20000;

	typedef struct {
		logic signed [CB-1:0] px, py, pz, vx, vy, vz;
	} agent_t;

	typedef struct packed {
		logic signed [31:0] fx, fy, fz;
		logic               brk;
	} force_t;

	typedef struct {
		agent_t a;
		logic   known;
		force_t f;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CB-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [CB-1:0] vel_x = '0, vel_y = '0, vel_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] force_x, force_y, force_z;
	logic braking;
	logic cfg_we = 1'b0;
	ssf_pkg::cfg_idx_t cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;

	longint tgt_x, tgt_y, tgt_z;
	longint unsigned spd, gain, stop_d;

	force_t pending_forces[$];
	int errors = 0;
	int idle_cycles = 0;
	bit hold_rx = 1'b0;
	bit stim_done = 1'b0;
	row_t rows[$];

	always #6 clk = ~clk;

	seek_steering_force_core #(.COORD_BITS(CB)) i_dut (.*);

	function automatic longint unsigned magn(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint round_div(longint num, longint unsigned den);
		longint unsigned q;
		q = (magn(num) + den / 2) / den;
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic force_t steer(agent_t a);
		force_t f;
		longint d[3], v[3];
		longint unsigned m[3], dsq, ssq, s, len, t, sq;
		int sh;
		longint want;
		d[0] = tgt_x - longint'(a.px);
		d[1] = tgt_y - longint'(a.py);
		d[2] = tgt_z - longint'(a.pz);
		v[0] = a.vx;
		v[1] = a.vy;
		v[2] = a.vz;
		sh = 0;
		dsq = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = magn(d[i]);
			if (m[i] >= 64'd1 << 31) sh = 1;
		end
		for (int i = 0; i < 3; i++) begin
			sq = m[i] * m[i];
			if (m[i] >= 64'd1 << 32) sq = '1;
			if (dsq > ~64'd0 - sq) dsq = '1;
			else dsq += sq;
		end
		ssq = stop_d * stop_d;
		if (dsq <= ssq) begin
			f.fx = clamp32(round_div(-v[0] * longint'(gain), 512));
			f.fy = clamp32(round_div(-v[1] * longint'(gain), 512));
			f.fz = clamp32(round_div(-v[2] * longint'(gain), 512));
			f.brk = 1'b1;
		end else begin
			s = 0;
			for (int i = 0; i < 3; i++) begin
				t = m[i] >> sh;
				s += t * t;
			end
			len = int_sqrt(s) << sh;
			if (len == 0) len = 1;
			for (int i = 0; i < 3; i++) begin
				want = round_div(d[i] * longint'(spd), len);
				d[i] = round_div((want - v[i]) * longint'(gain), 256);
			end
			f.fx = clamp32(d[0]);
			f.fy = clamp32(d[1]);
			f.fz = clamp32(d[2]);
			f.brk = 1'b0;
		end
		return f;
	endfunction

	task automatic write_reg(ssf_pkg::cfg_idx_t idx, logic [CW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ssf_pkg::REG_TARGET_X: tgt_x = longint'($signed(val));
			ssf_pkg::REG_TARGET_Y: tgt_y = longint'($signed(val));
			ssf_pkg::REG_TARGET_Z: tgt_z = longint'($signed(val));
			ssf_pkg::REG_MAX_SPEED: spd = val[22:0];
			ssf_pkg::REG_ACCEL_GAIN: gain = val[15:0];
			ssf_pkg::REG_STOP_DIST: stop_d = val[22:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_forces.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic int gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
			(($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
	endfunction

	task automatic send(agent_t a, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z} <= {a.px, a.py, a.pz, a.vx, a.vy, a.vz};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_forces.push_back(steer(a));
	endtask

	function automatic logic signed [CB-1:0] rnd_coord(int mode);
		case (mode)
			0: return CB'($urandom());
			1: return $signed(10'($urandom())) * 24'sd256;
			2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, {(CB - 1){1'b0}}} |
				((CB)'($urandom_range(0, 1) ? '1 : '0) >> 1);
			default: return $signed(16'($urandom()));
		endcase
	endfunction

	function automatic agent_t rnd_agent();
		agent_t a;
		int md;
		md = $urandom_range(0, 3);
		a.px = rnd_coord(md);
		a.py = rnd_coord(md);
		a.pz = rnd_coord(md);
		a.vx = rnd_coord($urandom_range(0, 3));
		a.vy = rnd_coord($urandom_range(0, 3));
		a.vz = rnd_coord($urandom_range(0, 3));
		if ($urandom_range(0, 4) == 0) begin
			a.px = CB'(tgt_x + $signed(8'($urandom())));
			a.py = CB'(tgt_y + $signed(8'($urandom())));
			a.pz = CB'(tgt_z + $signed(8'($urandom())));
		end
		return a;
	endfunction

	task automatic add_row(agent_t a, bit known, force_t f);
		row_t r;
		r.a = a;
		r.known = known;
		r.f = f;
		rows.push_back(r);
	endtask

	always @(posedge clk) begin
		force_t e;
		if (out_valid && !out_stall) begin
			if (pending_forces.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat");
			end else begin
				e = pending_forces.pop_front();
				if (force_x !== e.fx || force_y !== e.fy || force_z !== e.fz
						|| braking !== e.brk) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp %0d %0d %0d %b got %0d %0d %0d %b",
							e.fx, e.fy, e.fz, e.brk, force_x, force_y, force_z, braking);
				end
			end
		end
	end

	always @(posedge clk) begin
		int g;
		if (hold_rx) begin
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 29) == 0) begin
			out_stall <= 1'b1;
			g = $urandom_range(0, 7) == 0 ? $urandom_range(20, 80) : $urandom_range(1, 4);
			repeat (g) @(posedge clk);
			out_stall <= 1'b0;
		end else if (stim_done || $urandom_range(0, 3) != 0) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n || hold_rx)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		agent_t a;
		force_t f;
		tgt_x = 0; tgt_y = 0; tgt_z = 0;
		spd = 153600; gain = 256; stop_d = 25600;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero offset and zero velocity after reset: braking with zero force.
		a = '{0, 0, 0, 0, 0, 0};
		f = '{0, 0, 0, 1'b1};
		add_row(a, 1'b1, f);
		// Braking at reset gain: force is minus half the velocity.
		a = '{0, 0, 0, 24'sd512, -24'sd512, 24'sd2};
		f = '{-32'sd256, 32'sd256, -32'sd1, 1'b1};
		add_row(a, 1'b1, f);
		// Exactly on the stopping boundary still brakes.
		a = '{24'sd25600, 0, 0, 0, 0, 0};
		f = '{0, 0, 0, 1'b1};
		add_row(a, 1'b1, f);
		// Just outside the boundary: pulled toward the target at max speed.
		a = '{24'sd25601, 0, 0, 0, 0, 0};
		f = '{-32'sd153600, 0, 0, 1'b0};
		add_row(a, 1'b1, f);
		a = '{-24'sd8388608, 24'sd8388607, -24'sd8388608, 24'sd8388607, -24'sd8388608, 0};
		add_row(a, 1'b0, f);
		a = '{24'sd8388607, 24'sd8388607, 24'sd8388607, -24'sd8388608, -24'sd8388608,
			-24'sd8388608};
		add_row(a, 1'b0, f);
		a = '{0, -24'sd26000, 0, -24'sd8388608, 24'sd8388607, 24'sd1};
		add_row(a, 1'b0, f);
		foreach (rows[i]) send(rows[i].a, 1'b0);
		in_valid <= 1'b0;
		drain();
		foreach (rows[i])
			if (rows[i].known && steer(rows[i].a) != rows[i].f) begin
				errors++;
				if (errors <= 10) $display("directed row %0d table disagrees", i);
			end

		// Extreme settings: far target, full gain and speed, then zero speed and full stopping distance.
		write_reg(ssf_pkg::REG_TARGET_X, 24'h800000);
		write_reg(ssf_pkg::REG_TARGET_Y, 24'h7FFFFF);
		write_reg(ssf_pkg::REG_TARGET_Z, 24'h800000);
		write_reg(ssf_pkg::REG_MAX_SPEED, 24'h7FFFFF);
		write_reg(ssf_pkg::REG_ACCEL_GAIN, 24'h00FFFF);
		write_reg(ssf_pkg::REG_STOP_DIST, 24'h000000);
		write_reg(ssf_pkg::cfg_idx_t'(7), 24'h123456);
		for (int i = 0; i < 8; i++) send(rnd_agent(), 1'b0);
		a = '{24'sd8388607, -24'sd8388608, 24'sd8388607, 0, 0, 0};
		send(a, 1'b0);
		in_valid <= 1'b0;
		drain();
		write_reg(ssf_pkg::REG_STOP_DIST, 24'h7FFFFF);
		write_reg(ssf_pkg::REG_MAX_SPEED, 0);
		for (int i = 0; i < 8; i++) send(rnd_agent(), 1'b0);
		in_valid <= 1'b0;
		drain();

		// Long receiver hold-off while the sender keeps offering beats.
		hold_rx = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_rx = 1'b0;
			end
			for (int i = 0; i < 80; i++) send(rnd_agent(), 1'b0);
		join
		in_valid <= 1'b0;
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(ssf_pkg::REG_TARGET_X, $urandom());
			write_reg(ssf_pkg::REG_TARGET_Y, $urandom());
			write_reg(ssf_pkg::REG_TARGET_Z, ph == 0 ? 0 : $urandom());
			write_reg(ssf_pkg::REG_MAX_SPEED, ph == 1 ? '0 : $urandom_range(0, 24'h7FFFFF));
			write_reg(ssf_pkg::REG_ACCEL_GAIN, ph == 2 ? '0 : $urandom_range(0, 16'hFFFF));
			write_reg(ssf_pkg::REG_STOP_DIST,
				ph == 3 ? 24'h7FFFFF : $urandom_range(0, 24'h7FFFFF));
			for (int i = 0; i < 190; i++) send(rnd_agent(), 1'b1);
			in_valid <= 1'b0;
			drain();
		end

		stim_done = 1'b1;
		drain();
		if (errors == 0 && pending_forces.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
